FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/core/iirv_pkg.sv
package iirv_pkg;

	localparam int CAPACITY = 16;
	localparam int HANDLE_W = 32;

	localparam int REQ_W   = 3;
	localparam int POS_W   = 5;
	localparam int ENTRY_W = 32;
	localparam int FILL_W  = 5;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_BACK  = 3'd0,
		REQ_PUSH_FRONT = 3'd1,
		REQ_INSERT     = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_POP_FRONT  = 3'd4,
		REQ_REMOVE     = 3'd5,
		REQ_READ       = 3'd6,
		REQ_WRITE      = 3'd7
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_REMOVE = 2'd2,
		CELL_WRITE  = 2'd3
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t           cmd;
		logic [HANDLE_W-1:0] data;
	} cell_ctrl_t;

endpackage

FILE: rtl/core/iirv_cell.sv
module iirv_cell import iirv_pkg::*; (
	input  logic                clk,
	input  cell_ctrl_t          ctrl,
	input  logic                hit,
	input  logic                past_in,
	output logic                past_out,
	input  logic [HANDLE_W-1:0] left_data,
	input  logic [HANDLE_W-1:0] right_data,
	output logic [HANDLE_W-1:0] data,
	input  logic [HANDLE_W-1:0] rd_in,
	output logic [HANDLE_W-1:0] rd_out
);

	logic [HANDLE_W-1:0] slot_q;

	assign data     = slot_q;
	assign past_out = past_in | hit;
	assign rd_out   = rd_in | (hit ? slot_q : '0);

	always_ff @(posedge clk) begin
		unique case (ctrl.cmd)
			CELL_INSERT: begin
				if (hit) begin
					slot_q <= ctrl.data;
				end else if (past_in) begin
					slot_q <= left_data;
				end
			end
			CELL_REMOVE: begin
				if (hit || past_in) begin
					slot_q <= right_data;
				end
			end
			CELL_WRITE: begin
				if (hit) begin
					slot_q <= ctrl.data;
				end
			end
			CELL_HOLD: begin
				slot_q <= slot_q;
			end
			default: begin
				slot_q <= slot_q;
			end
		endcase
	end

endmodule

FILE: rtl/core/indexed_insert_remove_vector_unit.sv
// Ordered vector of up to CAPACITY handles held in a row of cells, one handle per cell.
// Every request (push or pop at either end, insert, remove, read or write at a position)
// selects a target cell, an end or the position; for an insert or remove the cells at and
// beyond it shift toward their neighbor in parallel. One request is accepted per cycle
// while in_stall is low. Each request gives one result through an output register; a new
// request is taken while that result is still shown unless the output is stalled. Full,
// empty and bad-position requests leave the vector unchanged and return a zero entry.
`include "assert_macros.svh"

module indexed_insert_remove_vector_unit import iirv_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [REQ_W-1:0]   req_type,
	input  logic [POS_W-1:0]   position,
	input  logic [ENTRY_W-1:0] entry_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [ENTRY_W-1:0] entry_out,
	output logic [FILL_W-1:0]  fill_count,
	output logic [1:0]         status
);

	logic [CNT_W-1:0]   count_q;
	logic               out_valid_q;
	logic [ENTRY_W-1:0] entry_out_q;
	logic [FILL_W-1:0]  fill_count_q;
	status_t            status_q;

	req_kind_t          req;
	logic               accept;
	logic [CMP_W-1:0]   pos_x;
	logic [CMP_W-1:0]   cnt_x;
	logic [CMP_W-1:0]   eff;
	logic               is_full;
	logic               is_empty;
	logic               rd_en;
	cell_cmd_t          cmd;
	status_t            st_d;
	logic [CNT_W-1:0]   count_d;
	cell_ctrl_t         ctrl;

	logic [CAPACITY-1:0] hit;
	logic [CAPACITY:0]   past;
	logic [HANDLE_W-1:0] cell_data [CAPACITY];
	logic [HANDLE_W-1:0] rd_chain  [CAPACITY+1];
	logic [HANDLE_W-1:0] got;

	assign accept   = in_valid & ~in_stall;
	assign in_stall = out_valid_q & out_stall;
	assign req      = req_kind_t'(req_type);
	assign pos_x    = CMP_W'(position);
	assign cnt_x    = CMP_W'(count_q);
	assign is_full  = (cnt_x == CMP_W'(CAPACITY));
	assign is_empty = (count_q == '0);

	always_comb begin
		eff   = '0;
		cmd   = CELL_HOLD;
		st_d  = ST_OK;
		rd_en = 1'b0;
		unique case (req)
			REQ_PUSH_BACK, REQ_PUSH_FRONT, REQ_INSERT: begin
				if (req == REQ_PUSH_BACK) begin
					eff = cnt_x;
				end else if (req == REQ_INSERT) begin
					eff = pos_x;
				end
				if (is_full) begin
					st_d = ST_FULL;
				end else if (req == REQ_INSERT && pos_x > cnt_x) begin
					st_d = ST_RANGE;
				end else begin
					cmd = CELL_INSERT;
				end
			end
			REQ_POP_BACK, REQ_POP_FRONT, REQ_REMOVE: begin
				if (req == REQ_POP_BACK) begin
					eff = cnt_x - CMP_W'(1);
				end else if (req == REQ_REMOVE) begin
					eff = pos_x;
				end
				if (is_empty) begin
					st_d = ST_EMPTY;
				end else if (req == REQ_REMOVE && pos_x >= cnt_x) begin
					st_d = ST_RANGE;
				end else begin
					cmd   = CELL_REMOVE;
					rd_en = 1'b1;
				end
			end
			REQ_READ, REQ_WRITE: begin
				eff = pos_x;
				if (is_empty) begin
					st_d = ST_EMPTY;
				end else if (pos_x >= cnt_x) begin
					st_d = ST_RANGE;
				end else if (req == REQ_READ) begin
					rd_en = 1'b1;
				end else begin
					cmd = CELL_WRITE;
				end
			end
			default: begin
				st_d = ST_OK;
			end
		endcase
	end

	always_comb begin
		unique case (cmd)
			CELL_INSERT: count_d = count_q + CNT_W'(1);
			CELL_REMOVE: count_d = count_q - CNT_W'(1);
			default:     count_d = count_q;
		endcase
	end

	assign ctrl.cmd  = accept ? cmd : CELL_HOLD;
	assign ctrl.data = HANDLE_W'(entry_value);

	assign past[0]     = 1'b0;
	assign rd_chain[0] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [HANDLE_W-1:0] left_d;
		logic [HANDLE_W-1:0] right_d;

		assign hit[i] = (eff == CMP_W'(i));

		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end

		iirv_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.hit        (hit[i]),
			.past_in    (past[i]),
			.past_out   (past[i+1]),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i]),
			.rd_in      (rd_chain[i]),
			.rd_out     (rd_chain[i+1])
		);
	end

	assign got = rd_en ? rd_chain[CAPACITY] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_out_q  <= ENTRY_W'(got);
			fill_count_q <= FILL_W'(count_d);
			status_q     <= st_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign entry_out  = entry_out_q;
	assign fill_count = fill_count_q;
	assign status     = status_q;

	`ASSERT_NEVER(a_count_bound, count_q > CNT_W'(CAPACITY), "Fill count exceeds capacity.")
	`ASSERT_CLK(a_fill_tracks, accept |=> fill_count == FILL_W'(count_q), "Reported fill count differs from stored count.")
	`ASSERT_CLK(a_err_keeps, (accept && st_d != ST_OK) |=> count_q == $past(count_q), "Rejected request changed the fill count.")
	`ASSERT_CLK(a_err_zero, (out_valid && status_q != ST_OK) |-> entry_out == '0, "Rejected request returned a nonzero entry.")

endmodule
